@@ sv/mpld_pkg.sv @@
// Package for the multiplexed PWM LED driver: request and result types, constants, gamma map.
`default_nettype none

package mpld_pkg;

  // Fixed field widths of the request and result channels.
  localparam int OPCODE_W      = 2;
  localparam int INDEX_W       = 5;
  localparam int LEVEL_W       = 5;
  localparam int FRAMES_W      = 8;
  localparam int DUTY_W        = 8;
  localparam int SLOT_W        = 8;
  localparam int DRIVE_W       = 18;
  localparam int DRIVE_IDX_W   = $clog2(DRIVE_W);

  // Number of the last slot in which each group is shown; slots are numbered from zero up to it.
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(254);

  // Request operation codes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_SET_LEVEL = 2'd0,
    OP_START     = 2'd1,
    OP_TICK      = 2'd2,
    OP_NOP       = 2'd3
  } opcode_t;

  // One request on the input channel.
  typedef struct packed {
    opcode_t             opcode;
    logic [INDEX_W-1:0]  led_index;
    logic [LEVEL_W-1:0]  level;
    logic [FRAMES_W-1:0] frame_count;
  } in_req_t;

  // One result on the output channel.
  typedef struct packed {
    logic [DRIVE_W-1:0] led_drive;
    logic               busy_res;
  } out_res_t;

  // Quadratic gamma map from level to duty; levels beyond the table read full duty.
  function automatic logic [DUTY_W-1:0] gamma_duty(input logic [LEVEL_W-1:0] lv);
    logic [DUTY_W-1:0] duty;
    case (lv)
      5'd0:    duty = 8'd0;
      5'd1:    duty = 8'd1;
      5'd2:    duty = 8'd4;
      5'd3:    duty = 8'd8;
      5'd4:    duty = 8'd14;
      5'd5:    duty = 8'd22;
      5'd6:    duty = 8'd32;
      5'd7:    duty = 8'd43;
      5'd8:    duty = 8'd56;
      5'd9:    duty = 8'd71;
      5'd10:   duty = 8'd88;
      5'd11:   duty = 8'd107;
      5'd12:   duty = 8'd127;
      5'd13:   duty = 8'd149;
      5'd14:   duty = 8'd173;
      5'd15:   duty = 8'd199;
      5'd16:   duty = 8'd226;
      default: duty = 8'd255;
    endcase
    return duty;
  endfunction

endpackage

`default_nettype wire

@@ sv/multiplexed_pwm_led_driver.sv @@
// Top level of the multiplexed PWM LED driver with gamma-mapped levels.
//
//   Channel   Direction  Handshake            Payload
//   in_       request    in_valid / in_stall  in_req  (opcode, led_index, level, frame_count)
//   out_      result     out_valid / out_stall out_res (led_drive, busy_res)
//
// Every request gives one result, registered on acceptance and shown in the next cycle;
// a request can be accepted in every cycle unless a result is held with out_stall high,
// so the block sustains one request per clock while not stalled. The result sits in the
// single register behind the slot counter, group duty latch and per-LED slot compares.
// Reset (rst_n low at a clock edge) clears all levels, duties and counters.
// in_stall is high only while a result is held and out_stall is high.
`default_nettype none

module multiplexed_pwm_led_driver #(
  parameter int LED_COUNT   = 18,
  parameter int LEVEL_COUNT = 18,
  parameter int GROUP_SIZE  = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mpld_pkg::in_req_t in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mpld_pkg::out_res_t     out_res
);
  import mpld_pkg::*;

  localparam int GROUP_TOTAL = (LED_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_W       = (GROUP_TOTAL > 1) ? $clog2(GROUP_TOTAL) : 1;
  localparam logic [GRP_W-1:0]   GRP_LAST  = GRP_W'(GROUP_TOTAL - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVEL_COUNT - 1);

  // Level store laid out as one row per group; unused members of a partial row stay zero.
  logic [LEVEL_W-1:0]  levels_r [GROUP_TOTAL][GROUP_SIZE];
  logic [DUTY_W-1:0]   duty_r   [GROUP_SIZE];
  logic [DUTY_W-1:0]   duty_nxt [GROUP_SIZE];
  logic [FRAMES_W-1:0] frames_r, frames_nxt;
  logic [GRP_W-1:0]    grp_r, grp_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                out_valid_r;
  out_res_t            out_res_r, out_res_nxt;

  logic                accept;
  logic                wr_en;
  logic                latch_en;
  logic [LEVEL_W-1:0]  level_sat;

  // Accept a request whenever the result register is empty or being emptied.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Saturate the level before it is stored.
  assign wr_en     = accept && (in_req.opcode == OP_SET_LEVEL);
  assign level_sat = (in_req.level > LEVEL_MAX) ? LEVEL_MAX : in_req.level;

  // Frame, group and slot sequencing.
  always_comb begin
    frames_nxt = frames_r;
    grp_nxt    = grp_r;
    slot_nxt   = slot_r;
    latch_en   = 1'b0;
    if (accept) begin
      case (in_req.opcode)
        OP_START: begin
          frames_nxt = in_req.frame_count;
          grp_nxt    = '0;
          slot_nxt   = '0;
          latch_en   = 1'b1;
        end
        OP_TICK: begin
          if (frames_r != '0) begin
            if (slot_r == LAST_SLOT) begin
              slot_nxt = '0;
              latch_en = 1'b1;
              if (grp_r == GRP_LAST) begin
                grp_nxt    = '0;
                frames_nxt = frames_r - FRAMES_W'(1);
              end else begin
                grp_nxt = grp_r + GRP_W'(1);
              end
            end else begin
              slot_nxt = slot_r + SLOT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Latch the new group's duties from its row of levels through the gamma map.
  always_comb begin
    for (int m = 0; m < GROUP_SIZE; m++) begin
      duty_nxt[m] = latch_en ? gamma_duty(levels_r[grp_nxt][m]) : duty_r[m];
    end
  end

  // Drive pattern and busy flag as they stand after this request.
  always_comb begin
    int led;
    out_res_nxt.led_drive = '0;
    out_res_nxt.busy_res  = (frames_nxt != '0);
    for (int m = 0; m < GROUP_SIZE; m++) begin
      led = int'(grp_nxt) * GROUP_SIZE + m;
      if (frames_nxt != '0 && led < DRIVE_W && slot_nxt < duty_nxt[m]) begin
        out_res_nxt.led_drive[led[DRIVE_IDX_W-1:0]] = 1'b1;
      end
    end
  end

  // Level store writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < GROUP_TOTAL; r++) begin
        for (int c = 0; c < GROUP_SIZE; c++) begin
          levels_r[r][c] <= '0;
        end
      end
    end else if (wr_en) begin
      for (int r = 0; r < GROUP_TOTAL; r++) begin
        for (int c = 0; c < GROUP_SIZE; c++) begin
          if ((r * GROUP_SIZE + c) < LED_COUNT &&
              int'(in_req.led_index) == r * GROUP_SIZE + c) begin
            levels_r[r][c] <= level_sat;
          end
        end
      end
    end
  end

  // Sequencing state and latched duties.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= '0;
      grp_r    <= '0;
      slot_r   <= '0;
      for (int m = 0; m < GROUP_SIZE; m++) begin
        duty_r[m] <= '0;
      end
    end else begin
      frames_r <= frames_nxt;
      grp_r    <= grp_nxt;
      slot_r   <= slot_nxt;
      for (int m = 0; m < GROUP_SIZE; m++) begin
        duty_r[m] <= duty_nxt[m];
      end
    end
  end

  // Result register: loads on every accepted request, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

@@ sv/mpld_checker.sv @@
// Port-level checker for the multiplexed PWM LED driver, with its bind statement.
`default_nettype none

module mpld_checker #(
  parameter int GROUP_SIZE = 3
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire mpld_pkg::in_req_t in_req,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire mpld_pkg::out_res_t out_res
);
  import mpld_pkg::*;

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  // Every accepted request shows a result in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request gave no result");

  // The block stalls requests only while a result is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("request stalled with empty result register");

  // At most GROUP_SIZE LEDs are lit, and nothing is lit when idle.
  a_group_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(out_res.led_drive) <= GROUP_SIZE) &&
                  (out_res.busy_res || out_res.led_drive == '0))
    else $error("drive pattern outside the current group");

  // A start with no frames leaves the display idle.
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req.opcode == OP_START && in_req.frame_count == '0
    |=> !out_res.busy_res)
    else $error("start with no frames left the block busy");

endmodule

bind multiplexed_pwm_led_driver mpld_checker #(.GROUP_SIZE(GROUP_SIZE)) u_mpld_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);

`default_nettype wire

@@ test/tb_multiplexed_pwm_led_driver.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the multiplexed PWM LED driver under random request and stall traffic.
module tb_multiplexed_pwm_led_driver;
  import mpld_pkg::*;

  localparam int LED_TOTAL   = 18;
  localparam int GROUP_LEDS  = 3;
  localparam int GROUP_TOTAL = 6;
  localparam int SLOTS       = 255;
  localparam int TOP_LEVEL   = 17;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_REQS = 900;

  typedef enum {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_THIRDS,
    STALL_BURSTS
  } stall_mode_t;

  // Tracks levels, latched duties and the frame position, and queues the expected drive.
  class led_drive_tracker_t;
    bit [7:0]    duty_lut [LED_TOTAL];
    bit [4:0]    levels [LED_TOTAL];
    bit [7:0]    latched [GROUP_LEDS];
    bit [7:0]    frames;
    int unsigned grp;
    int unsigned slot;
    int unsigned errors;
    out_res_t    pending_drive [$];

    function new();
      duty_lut = '{8'd0, 8'd1, 8'd4, 8'd8, 8'd14, 8'd22, 8'd32, 8'd43, 8'd56,
                   8'd71, 8'd88, 8'd107, 8'd127, 8'd149, 8'd173, 8'd199, 8'd226, 8'd255};
      foreach (levels[i]) levels[i] = '0;
      foreach (latched[m]) latched[m] = '0;
      frames = '0;
      grp = 0;
      slot = 0;
      errors = 0;
    endfunction

    function void latch_group();
      foreach (latched[m]) latched[m] = duty_lut[levels[grp * GROUP_LEDS + m]];
    endfunction

    // Applies one accepted request and records the drive that must follow it.
    function void note_request(in_req_t r);
      out_res_t e;
      bit [4:0] lv;
      case (r.opcode)
        OP_SET_LEVEL: begin
          if (r.led_index < LED_TOTAL) begin
            lv = (r.level > TOP_LEVEL) ? 5'(TOP_LEVEL) : r.level;
            levels[r.led_index] = lv;
          end
        end
        OP_START: begin
          frames = r.frame_count;
          grp = 0;
          slot = 0;
          latch_group();
        end
        OP_TICK: begin
          if (frames != 0) begin
            slot++;
            if (slot >= SLOTS) begin
              slot = 0;
              grp++;
              if (grp >= GROUP_TOTAL) begin
                grp = 0;
                frames--;
              end
              latch_group();
            end
          end
        end
        default: ;
      endcase
      e.led_drive = '0;
      if (frames != 0) begin
        for (int m = 0; m < GROUP_LEDS; m++) begin
          if (slot < latched[m]) e.led_drive[grp * GROUP_LEDS + m] = 1'b1;
        end
      end
      e.busy_res = (frames != 0);
      pending_drive.push_back(e);
    endfunction

    // Compares one result with the oldest expected drive.
    function void check_result(out_res_t a);
      out_res_t e;
      if (pending_drive.size() == 0) begin
        $display("%0t: unexpected result led_drive=%h busy_res=%b", $time,
                 a.led_drive, a.busy_res);
        errors++;
        return;
      end
      e = pending_drive.pop_front();
      if (a.led_drive !== e.led_drive) begin
        $display("%0t: led_drive expected %h actual %h", $time, e.led_drive, a.led_drive);
        errors++;
      end
      if (a.busy_res !== e.busy_res) begin
        $display("%0t: busy_res expected %b actual %b", $time, e.busy_res, a.busy_res);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_res_t out_res;

  led_drive_tracker_t drive_check;
  int          burst_left = 0;
  int unsigned req_count  = 0;
  bit          hold_go    = 1'b0;
  bit          hold_done  = 1'b0;

  multiplexed_pwm_led_driver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Every accepted result is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) drive_check.check_result(out_res);
  end

  // A request with every field random and the given operation.
  function automatic in_req_t rand_req(opcode_t op);
    in_req_t r;
    r.opcode      = op;
    r.led_index   = 5'($urandom_range(31));
    r.level       = 5'($urandom_range(31));
    r.frame_count = 8'($urandom_range(255));
    return r;
  endfunction

  // Offers one request in bursts separated by random gaps, and waits for acceptance.
  task automatic send_req(input in_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_req   = r;
    do @(posedge clk); while (in_stall);
    drive_check.note_request(r);
    req_count++;
  endtask

  task automatic send_set(input int idx, input int lvl);
    in_req_t r;
    r = rand_req(OP_SET_LEVEL);
    r.led_index = 5'(idx);
    r.level     = 5'(lvl);
    send_req(r);
  endtask

  task automatic send_start(input int fc);
    in_req_t r;
    r = rand_req(OP_START);
    r.frame_count = 8'(fc);
    send_req(r);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_req(rand_req(OP_TICK));
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (drive_check.pending_drive.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls in phases of differing patterns, with one long hold-off.
  initial begin
    stall_mode_t mode;
    int span;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_go && !hold_done) begin
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
        hold_done = 1'b1;
      end
      mode = stall_mode_t'($urandom_range(4));
      span = $urandom_range(20, 200);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:   out_stall = 1'b0;
          STALL_LIGHT:  out_stall = ($urandom_range(3) == 0);
          STALL_HEAVY:  out_stall = ($urandom_range(3) != 0);
          STALL_THIRDS: out_stall = (c % 3 == 0);
          default:      out_stall = ((c / 8) % 2 == 1);
        endcase
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("tb_multiplexed_pwm_led_driver NOT OK");
    $finish;
  end

  // Stimulus: directed cases, then random sequences up to the request budget.
  initial begin
    int kind;
    int fc;
    int n;
    drive_check = new();
    in_valid = 1'b0;
    in_req   = '0;
    rst_n    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: idle tick, saturation, ignored indexes, restarts and zero frames.
    send_ticks(1);
    send_set(0, TOP_LEVEL);
    send_set(17, 31);
    send_set(2, 1);
    send_set(20, 9);
    send_set(31, 31);
    send_req(rand_req(OP_NOP));
    send_start(0);
    send_start(1);
    send_ticks(2);
    // The new level must not show until the group is latched again.
    send_set(0, 0);
    send_ticks(1);
    send_start(255);
    send_req(rand_req(OP_NOP));
    send_ticks(2);
    send_set(1, 16);
    send_start(0);
    send_ticks(1);
    wait_drained();

    // Random part: mostly level writes, a start and a run of ticks; some noise.
    hold_go = 1'b1;
    req_count = 0;
    while (req_count < RANDOM_REQS) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        repeat ($urandom_range(4)) begin
          send_set(($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(17),
                   $urandom_range(31));
        end
        case ($urandom_range(9))
          0:       fc = 0;
          1:       fc = $urandom_range(255);
          2:       fc = 255;
          default: fc = $urandom_range(1, 3);
        endcase
        send_start(fc);
        n = ($urandom_range(4) == 0) ? $urandom_range(200, 700) : $urandom_range(1, 40);
        // Keep the run of ticks within the remaining budget.
        if (n > RANDOM_REQS - int'(req_count)) n = RANDOM_REQS - int'(req_count);
        if (n < 0) n = 0;
        repeat (n) begin
          if ($urandom_range(15) == 0) send_set($urandom_range(31), $urandom_range(31));
          else send_req(rand_req(OP_TICK));
        end
      end else begin
        repeat ($urandom_range(1, 12)) send_req(rand_req(opcode_t'($urandom_range(3))));
      end
      if ($urandom_range(7) == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (drive_check.errors == 0 && drive_check.pending_drive.size() == 0) begin
      $display("tb_multiplexed_pwm_led_driver OK");
    end else begin
      $display("tb_multiplexed_pwm_led_driver NOT OK");
    end
    $finish;
  end

endmodule
